[rtl/core/plb_pkg.sv]
// ----------------------------------------------------------------------------
// plb_pkg: shared types and constants of the positional list buffer
// Request and response layouts, request codes, status codes and the
// command that is broadcast along the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package plb_pkg;

  // list geometry
  localparam int CAPACITY = 16;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = 5;
  localparam int POS_W    = 8;
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;

  // request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_INSERT_AT  = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_DELETE_AT  = 3'd5,
    MODE_READ_AT    = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_e;

  // response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // per-cycle cell operation
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_e;

  // request payload
  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
  } in_req_t;

  // response payload
  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data_out;
    logic [COUNT_W-1:0]       count;
  } out_rsp_t;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_e          op;
    logic [POS_W-1:0]  at;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

  // decoded control for one request
  typedef struct packed {
    cell_cmd_t          cmd;
    status_e            status;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_sel;
    logic [COUNT_W-1:0] count;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/core/positional_list_buffer_unit.sv]
// ----------------------------------------------------------------------------
// positional_list_buffer_unit: bounded ordered list of signed values
// Insert, delete and read at front, back or any position, held in a
// chain of cells that shift locally; one response per request.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake                 payload
//   in        request    in_valid_i / in_stall_o   in_req_i   (mode, value, position)
//   out       response   out_valid_o / out_stall_i out_rsp_o  (status, data_out, count)
//
// - one request per cycle while in_stall_o is low; its response appears in the
//   output register in the cycle after acceptance
// - every cell decides in the same cycle to load, shift or hold, so an
//   insert or delete anywhere in the chain is done by all cells together
// - reset empties the list (count 0); element storage is not cleared
// - in_stall_o rises only while a response waits and out_stall_i is high
//
`default_nettype none

module positional_list_buffer_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire plb_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output plb_pkg::out_rsp_t      out_rsp_o
);

  logic                        fire;
  logic [plb_pkg::COUNT_W-1:0] occ_d, occ_q;
  logic                        out_valid_d, out_valid_q;
  plb_pkg::out_rsp_t           rsp_d, rsp_q;
  plb_pkg::ctrl_t              ctrl;
  logic [plb_pkg::DATA_W-1:0]  vals [plb_pkg::CAPACITY];

  // request handshake
  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;

  // decode
  plb_ctrl u_ctrl (
    .fire_i (fire),
    .req_i  (in_req_i),
    .occ_i  (occ_q),
    .ctrl_o (ctrl)
  );

  // cell chain
  for (genvar g = 0; g < plb_pkg::CAPACITY; g++) begin : g_cell
    logic [plb_pkg::DATA_W-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = ctrl.cmd.value;
    end else begin : g_mid_l
      assign left = vals[g-1];
    end
    if (g == plb_pkg::CAPACITY - 1) begin : g_last
      assign right = vals[g];
    end else begin : g_mid_r
      assign right = vals[g+1];
    end
    plb_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (ctrl.cmd),
      .left_i  (left),
      .right_i (right),
      .value_o (vals[g])
    );
  end

  // response build
  always_comb begin
    rsp_d.status   = ctrl.status;
    rsp_d.data_out = ctrl.rd_en ? vals[ctrl.rd_sel] : '0;
    rsp_d.count    = ctrl.count;
  end

  // count and output valid next state
  always_comb begin
    occ_d       = fire ? ctrl.count : occ_q;
    out_valid_d = fire || (out_valid_q && out_stall_i);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
    end
  end

  // response register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

[rtl/core/plb_cell.sv]
// ----------------------------------------------------------------------------
// plb_cell: one storage cell of the list chain
// Holds the element at its own position and, on an insert or delete,
// takes the value of its left or right neighbor or the new element.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_cell #(
  parameter int IDX = 0
) (
  input  wire logic                       clk_i,
  input  wire plb_pkg::cell_cmd_t         cmd_i,
  input  wire logic [plb_pkg::DATA_W-1:0] left_i,
  input  wire logic [plb_pkg::DATA_W-1:0] right_i,
  output logic      [plb_pkg::DATA_W-1:0] value_o
);

  localparam logic [plb_pkg::POS_W-1:0] IDX_L = plb_pkg::POS_W'(IDX);

  logic [plb_pkg::DATA_W-1:0] value_d, value_q;

  // local shift decision from the broadcast position
  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      plb_pkg::CELL_INSERT: begin
        if (IDX_L == cmd_i.at) begin
          value_d = cmd_i.value;
        end else if (IDX_L > cmd_i.at) begin
          value_d = left_i;
        end
      end
      plb_pkg::CELL_DELETE: begin
        if (IDX_L >= cmd_i.at) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // element storage
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

`default_nettype wire

[rtl/core/plb_ctrl.sv]
// ----------------------------------------------------------------------------
// plb_ctrl: request decoder
// Works out the target position, the status, the next element count
// and the command that the cell chain carries out.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_ctrl (
  input  wire logic                        fire_i,
  input  wire plb_pkg::in_req_t            req_i,
  input  wire logic [plb_pkg::COUNT_W-1:0] occ_i,
  output plb_pkg::ctrl_t                   ctrl_o
);

  localparam logic [plb_pkg::COUNT_W-1:0] CAP_L = plb_pkg::COUNT_W'(plb_pkg::CAPACITY);

  plb_pkg::mode_e             mode;
  logic [plb_pkg::POS_W-1:0]  occ_ext;
  logic [plb_pkg::POS_W-1:0]  last_ext;
  logic [plb_pkg::POS_W-1:0]  at;
  plb_pkg::cell_op_e          op;

  assign mode     = plb_pkg::mode_e'(req_i.mode);
  assign occ_ext  = plb_pkg::POS_W'(occ_i);
  assign last_ext = plb_pkg::POS_W'(occ_i - plb_pkg::COUNT_W'(1));

  // target position per request code
  always_comb begin
    case (mode)
      plb_pkg::MODE_PUSH_FRONT: at = '0;
      plb_pkg::MODE_POP_FRONT:  at = '0;
      plb_pkg::MODE_PUSH_BACK:  at = occ_ext;
      plb_pkg::MODE_POP_BACK:   at = last_ext;
      default:                  at = req_i.position;
    endcase
  end

  // status, count and cell operation
  always_comb begin
    op            = plb_pkg::CELL_HOLD;
    ctrl_o.status = plb_pkg::ST_OK;
    ctrl_o.rd_en  = 1'b0;
    ctrl_o.count  = occ_i;
    case (mode)
      plb_pkg::MODE_PUSH_FRONT, plb_pkg::MODE_PUSH_BACK, plb_pkg::MODE_INSERT_AT: begin
        if (occ_i >= CAP_L) begin
          ctrl_o.status = plb_pkg::ST_FULL;
        end else if (at > occ_ext) begin
          ctrl_o.status = plb_pkg::ST_RANGE;
        end else begin
          op           = plb_pkg::CELL_INSERT;
          ctrl_o.count = occ_i + plb_pkg::COUNT_W'(1);
        end
      end
      plb_pkg::MODE_POP_FRONT, plb_pkg::MODE_POP_BACK, plb_pkg::MODE_DELETE_AT: begin
        if (occ_i == '0) begin
          ctrl_o.status = plb_pkg::ST_EMPTY;
        end else if (at >= occ_ext) begin
          ctrl_o.status = plb_pkg::ST_RANGE;
        end else begin
          op           = plb_pkg::CELL_DELETE;
          ctrl_o.rd_en = 1'b1;
          ctrl_o.count = occ_i - plb_pkg::COUNT_W'(1);
        end
      end
      plb_pkg::MODE_READ_AT: begin
        if (occ_i == '0) begin
          ctrl_o.status = plb_pkg::ST_EMPTY;
        end else if (at >= occ_ext) begin
          ctrl_o.status = plb_pkg::ST_RANGE;
        end else begin
          ctrl_o.rd_en = 1'b1;
        end
      end
      default: ctrl_o.count = '0;
    endcase
    // cells only move on an accepted request
    ctrl_o.cmd.op    = fire_i ? op : plb_pkg::CELL_HOLD;
    ctrl_o.cmd.at    = at;
    ctrl_o.cmd.value = req_i.value;
    ctrl_o.rd_sel    = at[plb_pkg::IDX_W-1:0];
  end

endmodule

`default_nettype wire

[rtl/core/plb_checker.sv]
// ----------------------------------------------------------------------------
// plb_checker: port-level checks for the positional list buffer
// Watches the handshakes and the response fields over time.
// ----------------------------------------------------------------------------
`default_nettype none

module plb_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire plb_pkg::out_rsp_t out_rsp_o
);

  // a held response stays valid
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("response dropped while stalled");

  // requests stall only behind a waiting response
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("request stalled without a waiting response");

  // count stays within capacity
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_rsp_o.count <= plb_pkg::COUNT_W'(plb_pkg::CAPACITY))
    else $error("count above capacity");

  // a full status reports a full list
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == plb_pkg::ST_FULL
      |-> out_rsp_o.count == plb_pkg::COUNT_W'(plb_pkg::CAPACITY))
    else $error("full status with list not full");

  // an empty status reports an empty list and no data
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == plb_pkg::ST_EMPTY
      |-> out_rsp_o.count == '0 && out_rsp_o.data_out == '0)
    else $error("empty status with elements or data");

endmodule

bind positional_list_buffer_unit plb_checker u_plb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_rsp_o   (out_rsp_o)
);

`default_nettype wire
